// File: src/cobs_pkg.sv
// ---------------------------------------------------------------------------
// cobs_pkg: shared types and constants for the COBS frame decoder
// Holds the input and result item structs, the decoder mode codes and the
// frame buffer sizing constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cobs_pkg;

	// frame buffer sizing
	localparam int BUFFER_DEPTH = 1024;
	localparam int IDX_W        = $clog2(BUFFER_DEPTH);   // write index width
	localparam int FILL_W       = 11;                     // fill count, holds the depth itself
	localparam int CAP_W        = 11;
	localparam int CFG_DATA_W   = 11;
	localparam int CFG_IDX_W    = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 1'd1;

	// reset values of the configuration registers
	localparam logic [CAP_W-1:0] CAPACITY_RST  = CAP_W'(1024);
	localparam logic [7:0]       DELIMITER_RST = 8'd0;

	// request kinds
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_DROP = 1'b1;

	// decoder mode
	typedef enum logic [1:0] {
		MODE_END     = 2'd0,
		MODE_READING = 2'd1,
		MODE_FAIL    = 2'd2
	} cobs_mode_t;

	// input item
	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} cobs_in_t;

	// result item
	typedef struct packed {
		logic              accepted;
		logic              write_valid;
		logic [IDX_W-1:0]  write_index;
		logic [7:0]        write_value;
		logic              frame_end;
		logic              frame_ready;
		logic [FILL_W-1:0] frame_length;
		logic              frame_invalid;
	} cobs_out_t;

endpackage

`default_nettype wire

// File: src/cobs_frame_decoder_core.sv
// ---------------------------------------------------------------------------
// cobs_frame_decoder_core: byte-at-a-time COBS frame decoder
// Decodes one encoded byte or drop request per item and produces one
// result item with the buffer write and the frame status.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one received byte
//   or a drop request per item. Output channel (out_valid / out_stall /
//   out_data) returns exactly one result item per input item, in order.
//   Each result holds an optional write (index and value) for an external
//   frame buffer plus end-of-frame, ready, length and invalid flags.
//   Throughput: one item per cycle while in_stall is low; the decoder state
//   (mode, block bytes left, fill index) is registered when an item is taken.
//   A two-entry output buffer (result register plus skid register) lets an
//   item be accepted while the previous result still waits; in_stall rises
//   only once both entries hold results, so it is a register output.
//   Reset (arst_n low) puts the decoder in end-of-frame mode with an empty
//   frame, capacity 1024 and delimiter 0, and empties the output buffer.
//   Configuration (cfg_we, cfg_index, cfg_wdata) is to be written by the user
//   only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cobs_frame_decoder_core (
	input  wire                                clk,
	input  wire                                arst_n,
	// input items
	input  wire                                in_valid,
	output logic                               in_stall,
	input  cobs_pkg::cobs_in_t                 in_data,
	// result items
	output logic                               out_valid,
	input  wire                                out_stall,
	output cobs_pkg::cobs_out_t                out_data,
	// configuration
	input  wire                                cfg_we,
	input  wire  [cobs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [cobs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import cobs_pkg::*;

	// configuration registers
	logic [CAP_W-1:0]  capacity_q;
	logic [7:0]        delimiter_q;

	// decoder state
	cobs_mode_t        mode_q, mode_d;
	logic [7:0]        block_left_q, block_left_d;
	logic [FILL_W-1:0] fill_index_q, fill_index_d;
	logic              last_full_q, last_full_d;

	// output buffer
	logic              res_valid_q, skid_valid_q;
	cobs_out_t         res_q, skid_q;
	cobs_out_t         res_d;

	logic              in_take, out_take;
	logic [FILL_W-1:0] eff_cap;
	logic              is_code, do_write, overflow;

	assign in_take  = in_valid && !in_stall;
	assign out_take = res_valid_q && !out_stall;
	assign in_stall = skid_valid_q;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// effective capacity: min(capacity, buffer depth)
	assign eff_cap = (capacity_q > FILL_W'(BUFFER_DEPTH)) ? FILL_W'(BUFFER_DEPTH) : capacity_q;

	assign is_code  = (block_left_q == 8'd0);
	assign do_write = !is_code || !last_full_q;
	assign overflow = do_write && (fill_index_q >= eff_cap);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RST;
			delimiter_q <= DELIMITER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY:  capacity_q  <= CAP_W'(cfg_wdata);
				CFG_DELIMITER: delimiter_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// next state and result of one item
	always_comb begin
		mode_d       = mode_q;
		block_left_d = block_left_q;
		fill_index_d = fill_index_q;
		last_full_d  = last_full_q;
		res_d        = '0;
		res_d.accepted = 1'b1;

		if (in_data.req_type == REQ_DROP) begin
			mode_d       = MODE_END;
			block_left_d = 8'd0;
			fill_index_d = '0;
			last_full_d  = 1'b0;
		end else if (in_data.rx_byte == delimiter_q) begin
			if (mode_q == MODE_END) begin
				fill_index_d = '0;
				block_left_d = 8'd0;
			end else begin
				// delimiter mid-block or after failure discards the frame
				if (mode_q != MODE_READING || !is_code) begin
					fill_index_d = '0;
					block_left_d = 8'd0;
				end
				mode_d         = MODE_END;
				res_d.accepted = 1'b0;
			end
		end else begin
			unique case (mode_q)
				MODE_END: begin
					block_left_d = in_data.rx_byte - 8'd1;
					last_full_d  = (in_data.rx_byte == 8'hFF);
					mode_d       = MODE_READING;
				end
				MODE_READING: begin
					if (overflow) begin
						mode_d         = MODE_FAIL;
						fill_index_d   = '0;
						res_d.accepted = 1'b0;
					end else begin
						if (do_write) begin
							res_d.write_valid = 1'b1;
							res_d.write_index = fill_index_q[IDX_W-1:0];
							res_d.write_value = is_code ? 8'd0 : in_data.rx_byte;
							fill_index_d      = fill_index_q + FILL_W'(1);
						end
						if (is_code) begin
							block_left_d = in_data.rx_byte - 8'd1;
							last_full_d  = (in_data.rx_byte == 8'hFF);
						end else begin
							block_left_d = block_left_q - 8'd1;
						end
					end
				end
				default: ;  // fail: byte ignored
			endcase
		end

		// frame status after this item
		res_d.frame_end     = (mode_d == MODE_END);
		res_d.frame_ready   = res_d.frame_end && (fill_index_d != '0);
		res_d.frame_length  = res_d.frame_ready ? fill_index_d : '0;
		res_d.frame_invalid = !res_d.frame_ready && (mode_d != MODE_READING);
	end

	// decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_END;
			block_left_q <= 8'd0;
			fill_index_q <= '0;
			last_full_q  <= 1'b0;
		end else if (in_take) begin
			mode_q       <= mode_d;
			block_left_q <= block_left_d;
			fill_index_q <= fill_index_d;
			last_full_q  <= last_full_d;
		end
	end

	// output buffer control: result register fed by new item or skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || out_take) begin
				res_valid_q  <= skid_valid_q || in_take;
				skid_valid_q <= 1'b0;
			end else if (in_take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (!res_valid_q || out_take) begin
			if (skid_valid_q) begin
				res_q <= skid_q;
			end else if (in_take) begin
				res_q <= res_d;
			end
		end
		if (in_take && res_valid_q && !out_take) begin
			skid_q <= res_d;
		end
	end

endmodule

`default_nettype wire
